// ===== rtl/core/mlnp_pkg.sv =====
// ----------------------------------------------------------------------------
// mlnp_pkg: shared types and constants for the mono last-note controller
// Codes, stack entry layout, stack command group, result layout, states.
// ----------------------------------------------------------------------------
package mlnp_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam int CHAN_W   = 4;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int AMT_W    = 14;
   localparam int PRS_W    = 7;
   localparam int CODE_W   = 3;
   localparam int NUM_CHAN = 16;

   localparam logic [AMT_W-1:0] WHEEL_CENTRE = 14'd8192;
   localparam logic [VEL_W-1:0] VEL_FULL     = 7'd127;

   // input function codes
   localparam logic [CODE_W-1:0] FN_NOTE_ON  = 3'd0;
   localparam logic [CODE_W-1:0] FN_NOTE_OFF = 3'd1;
   localparam logic [CODE_W-1:0] FN_ALL_OFF  = 3'd2;
   localparam logic [CODE_W-1:0] FN_WHEEL    = 3'd3;
   localparam logic [CODE_W-1:0] FN_TOUCH    = 3'd4;

   // result action codes
   localparam logic [CODE_W-1:0] ACT_NONE    = 3'd0;
   localparam logic [CODE_W-1:0] ACT_START   = 3'd1;
   localparam logic [CODE_W-1:0] ACT_LEGATO  = 3'd2;
   localparam logic [CODE_W-1:0] ACT_RELEASE = 3'd3;
   localparam logic [CODE_W-1:0] ACT_TOUCH   = 3'd4;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  vel;
   } entry_type;

   typedef struct packed {
      logic             clr_hit;
      logic             step_hit;
      logic             shift_hit;
      logic             shift_all;
      logic             push;
      logic [IDX_W-1:0] push_idx;
   } stack_cmd_type;

   typedef struct packed {
      logic [CODE_W-1:0] action;
      logic [CHAN_W-1:0] chan;
      logic [NOTE_W-1:0] note;
      logic [VEL_W-1:0]  velocity;
      logic [AMT_W-1:0]  wheel;
      logic [PRS_W-1:0]  pressure;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_REMOVE,
      ST_PUSH,
      ST_FALLBACK,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/mlnp_cell.sv =====
// ----------------------------------------------------------------------------
// mlnp_cell: one note stack slot
// Holds one entry, takes its upper neighbor on a shift, and ripples the
// match flag upward one slot per search cycle.
// ----------------------------------------------------------------------------
module mlnp_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  mlnp_pkg::stack_cmd_type cmd,
   input  logic                    load_sel,
   input  logic                    in_range,
   input  mlnp_pkg::entry_type     key,
   input  mlnp_pkg::entry_type     upper,
   input  logic                    hit_lower,
   output mlnp_pkg::entry_type     entry,
   output logic                    hit
);
   import mlnp_pkg::*;

   entry_type entry_ff, entry_in;
   logic      hit_ff, hit_in;
   logic      match;

   assign match = in_range && (entry_ff.chan == key.chan) && (entry_ff.note == key.note);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push && load_sel) begin
         entry_in = key;
      end else if (cmd.shift_all || (cmd.shift_hit && hit_ff)) begin
         entry_in = upper;
      end
      hit_in = hit_ff;
      if (cmd.clr_hit) begin
         hit_in = 1'b0;
      end else if (cmd.step_hit) begin
         hit_in = match || hit_lower;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== rtl/core/mlnp_stack.sv =====
// ----------------------------------------------------------------------------
// mlnp_stack: chain of note stack cells
// Cell 0 holds the oldest note; the top is the cell below the fill count.
// ----------------------------------------------------------------------------
module mlnp_stack (
   input  logic                             clock,
   input  logic                             reset,
   input  mlnp_pkg::stack_cmd_type          cmd,
   input  mlnp_pkg::entry_type              key,
   input  logic [mlnp_pkg::CNT_W-1:0]       count,
   output mlnp_pkg::entry_type              top,
   output logic                             found
);
   import mlnp_pkg::*;

   entry_type            entries [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] hits;
   logic [CNT_W-1:0]     top_pos;

   for (genvar j = 0; j < STACK_DEPTH; j++) begin : g_cell
      entry_type upper;
      logic      hit_lower;

      if (j == STACK_DEPTH - 1) begin : g_top
         assign upper = entries[j];
      end else begin : g_mid
         assign upper = entries[j+1];
      end

      if (j == 0) begin : g_bot
         assign hit_lower = 1'b0;
      end else begin : g_up
         assign hit_lower = hits[j-1];
      end

      mlnp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .load_sel  (cmd.push_idx == IDX_W'(j)),
         .in_range  (count > CNT_W'(j)),
         .key       (key),
         .upper     (upper),
         .hit_lower (hit_lower),
         .entry     (entries[j]),
         .hit       (hits[j])
      );
   end

   // the top match flag has seen every cell once the ripple has settled
   assign found   = hits[STACK_DEPTH-1];
   assign top_pos = count - CNT_W'(1);
   assign top     = entries[top_pos[IDX_W-1:0]];

endmodule

// ===== rtl/core/mono_last_note_priority.sv =====
// ----------------------------------------------------------------------------
// mono_last_note_priority: monophonic last-note-priority voice controller
// Keeps the stack of held notes, stores the pitch wheel per channel and
// turns each MIDI event beat into exactly one voice command beat.
//
// Usage:
//  - req_* carries one event per beat: req_tuser is the function code,
//    req_tdata the channel, note, velocity, amount and the voice/pedal flags.
//  - rsp_* returns one command per event, action code in rsp_tuser.
//  - Note-on and note-off run the search, remove and then push (note-on) or
//    fallback (note-off of a held note) steps before the emit step: the match
//    flag ripples one cell per cycle before the stack shifts. All other events
//    go straight to emit. One event is worked on at a time; req_tready is high
//    only while idle.
//  - A finished result sits in the output register; the controller returns
//    to idle once the previous result has been taken, so a stalled receiver
//    blocks at most one further result.
//  - Reset (synchronous, active high) empties the stack, clears key-down and
//    the voice channel, centers every channel's wheel and drops any result.
// ----------------------------------------------------------------------------
module mono_last_note_priority (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: chan[3:0] note[10:4] velocity[17:11] amount[31:18]
   //            voice_active[32] pedal_held[33], zero fill [39:34]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [2:0]  req_tuser,   // func[2:0]
   // rsp_tdata: out_chan[3:0] out_note[10:4] out_velocity[17:11]
   //            wheel[31:18] pressure[38:32], zero fill [39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic [2:0]  rsp_tuser    // action[2:0]
);
   import mlnp_pkg::*;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  stack_count_ff, stack_count_in;
   logic              key_down_ff, key_down_in;
   logic [CHAN_W-1:0] voice_chan_ff, voice_chan_in;
   logic [AMT_W-1:0]  wheel_ff [NUM_CHAN];
   logic              wheel_we;

   // latched event
   logic [CODE_W-1:0] func_ff, func_in;
   entry_type         key_ff, key_in;
   logic              active_ff, active_in;
   logic              pedal_ff, pedal_in;
   logic              was_top_ff, was_top_in;

   result_type        res_ff, res_in;
   result_type        rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   stack_cmd_type     cmd;
   entry_type         top;
   logic              found;
   logic              req_fire;
   logic              retrig;
   logic              full;

   // unpack the request beat
   entry_type         req_entry;
   logic [AMT_W-1:0]  req_amount;
   logic              req_active, req_pedal;
   logic [CODE_W-1:0] req_func;

   assign req_entry.chan = req_tdata[3:0];
   assign req_entry.note = req_tdata[10:4];
   assign req_entry.vel  = req_tdata[17:11];
   assign req_amount     = req_tdata[31:18];
   assign req_active     = req_tdata[32];
   assign req_pedal      = req_tdata[33];
   // a note-on with zero velocity is a note-off
   assign req_func = (req_tuser == FN_NOTE_ON && req_entry.vel == '0) ? FN_NOTE_OFF
                                                                       : req_tuser;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   mlnp_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .key   (key_ff),
      .count (stack_count_ff),
      .top   (top),
      .found (found)
   );

   function automatic result_type play(entry_type n, logic rt, logic [AMT_W-1:0] whl);
      result_type r;
      r          = '0;
      r.action   = rt ? ACT_START : ACT_LEGATO;
      r.chan     = n.chan;
      r.note     = n.note;
      r.velocity = n.vel;
      r.wheel    = whl;
      return r;
   endfunction

   function automatic result_type release_cmd(logic [CHAN_W-1:0] ch, logic [VEL_W-1:0] v);
      result_type r;
      r          = '0;
      r.action   = ACT_RELEASE;
      r.chan     = ch;
      r.velocity = v;
      return r;
   endfunction

   assign retrig = !active_ff || !key_down_ff;
   assign full   = (stack_count_ff == CNT_W'(STACK_DEPTH));

   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      stack_count_in = stack_count_ff;
      key_down_in    = key_down_ff;
      voice_chan_in  = voice_chan_ff;
      func_in        = func_ff;
      key_in         = key_ff;
      active_in      = active_ff;
      pedal_in       = pedal_ff;
      was_top_in     = was_top_ff;
      res_in         = res_ff;
      wheel_we       = 1'b0;
      cmd            = '0;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in   = req_func;
               key_in    = req_entry;
               active_in = req_active;
               pedal_in  = req_pedal;
               res_in    = '0;
               state_in  = ST_EMIT;
               case (req_func)
                  FN_NOTE_ON, FN_NOTE_OFF: begin
                     cmd.clr_hit = 1'b1;
                     was_top_in  = (stack_count_ff != '0) && (top.chan == req_entry.chan)
                                   && (top.note == req_entry.note);
                     scan_in     = '0;
                     state_in    = ST_SEARCH;
                  end
                  FN_ALL_OFF: begin
                     stack_count_in = '0;
                     key_down_in    = 1'b0;
                     if (req_active && voice_chan_ff == req_entry.chan) begin
                        res_in = release_cmd(voice_chan_ff, VEL_FULL);
                     end
                  end
                  FN_WHEEL: begin
                     wheel_we = 1'b1;
                  end
                  FN_TOUCH: begin
                     if (stack_count_ff != '0 && voice_chan_ff == req_entry.chan) begin
                        res_in.action   = ACT_TOUCH;
                        res_in.chan     = voice_chan_ff;
                        res_in.pressure = req_amount[PRS_W-1:0];
                     end
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // advance the match ripple one cell
            cmd.step_hit = 1'b1;
            scan_in      = scan_ff + IDX_W'(1);
            if (scan_ff == IDX_W'(STACK_DEPTH - 1)) begin
               state_in = ST_REMOVE;
            end
         end
         ST_REMOVE: begin
            if (found) begin
               cmd.shift_hit  = 1'b1;
               stack_count_in = stack_count_ff - CNT_W'(1);
            end
            if (func_ff == FN_NOTE_ON) begin
               state_in = ST_PUSH;
            end else if (found) begin
               state_in = ST_FALLBACK;
            end else begin
               res_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_PUSH: begin
            // when full, drop the oldest and load the top in one shift
            cmd.push      = 1'b1;
            cmd.shift_all = full;
            cmd.push_idx  = full ? IDX_W'(STACK_DEPTH - 1) : stack_count_ff[IDX_W-1:0];
            if (!full) begin
               stack_count_in = stack_count_ff + CNT_W'(1);
            end
            res_in      = play(key_ff, retrig, wheel_ff[key_ff.chan]);
            key_down_in = 1'b1;
            if (retrig) begin
               voice_chan_in = key_ff.chan;
            end
            state_in = ST_EMIT;
         end
         ST_FALLBACK: begin
            res_in = '0;
            if (stack_count_ff != '0) begin
               if (was_top_ff) begin
                  res_in      = play(top, retrig, wheel_ff[top.chan]);
                  key_down_in = 1'b1;
                  if (retrig) begin
                     voice_chan_in = top.chan;
                  end
               end
            end else if (active_ff) begin
               key_down_in = 1'b0;
               if (!pedal_ff) begin
                  res_in = release_cmd(voice_chan_ff, key_ff.vel);
               end
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scan_ff        <= '0;
         stack_count_ff <= '0;
         key_down_ff    <= 1'b0;
         voice_chan_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_CHAN; i++) begin
            wheel_ff[i] <= WHEEL_CENTRE;
         end
      end else begin
         state_ff       <= state_in;
         scan_ff        <= scan_in;
         stack_count_ff <= stack_count_in;
         key_down_ff    <= key_down_in;
         voice_chan_ff  <= voice_chan_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (wheel_we) begin
            wheel_ff[req_entry.chan] <= req_amount;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      active_ff   <= active_in;
      pedal_ff    <= pedal_in;
      was_top_ff  <= was_top_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.action;
   assign rsp_tdata  = {1'b0, rsp_data_ff.pressure, rsp_data_ff.wheel,
                        rsp_data_ff.velocity, rsp_data_ff.note, rsp_data_ff.chan};

   // an accepted event always leaves idle in the cycle after it is accepted
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted event did not start processing");

   // a new result only appears out of the emit step
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result appeared outside emit");

   // the fill count never passes the stack depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count overflow");

   // a push always leaves at least one held note and key down
   a_push_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH |=> (stack_count_ff != '0) && key_down_ff)
      else $error("push left stack empty");

endmodule
